### rtl/imaenc_pkg.sv
// Shared types, constants and tables for the IMA-ADPCM block encoder.
package imaenc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int BYTE_W     = 8;
    localparam int POS_W      = 7;
    localparam int STEP_W     = 15;
    localparam int GROUPS_W   = 8;
    localparam int CHAN_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    // Block position: up to 2 * (1 + 8 * 255) - 1 = 4081
    localparam int CNT_W      = 12;
    localparam int NUM_W      = SAMPLE_W + 2;     // 4 * |d|
    localparam int PROD_W     = STEP_W + 4;       // step * (2q + 1)

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GROUPS_PER_BLOCK = 1'b1;

    localparam logic [CHAN_W-1:0]   CHAN_RESET   = 2'd1;
    localparam logic [GROUPS_W-1:0] GROUPS_RESET = 8'd80;

    localparam logic [POS_W-1:0] STEP_TOP = 7'd88;

    localparam logic signed [SAMPLE_W-1:0] PRED_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] PRED_MIN = 16'sh8000;

    // One sample, classified by the front end
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       is_header;
        logic                       ch;
        logic [2:0]                 k;
        logic                       at_end;
    } t_job;

    localparam logic [STEP_W-1:0] STEP_SIZES [0:88] = '{
        15'd7,     15'd8,     15'd9,     15'd10,    15'd11,
        15'd12,    15'd13,    15'd14,    15'd16,    15'd17,
        15'd19,    15'd21,    15'd23,    15'd25,    15'd28,
        15'd31,    15'd34,    15'd37,    15'd41,    15'd45,
        15'd50,    15'd55,    15'd60,    15'd66,    15'd73,
        15'd80,    15'd88,    15'd97,    15'd107,   15'd118,
        15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
        15'd209,   15'd230,   15'd253,   15'd279,   15'd307,
        15'd337,   15'd371,   15'd408,   15'd449,   15'd494,
        15'd544,   15'd598,   15'd658,   15'd724,   15'd796,
        15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,
        15'd1411,  15'd1552,  15'd1707,  15'd1878,  15'd2066,
        15'd2272,  15'd2499,  15'd2749,  15'd3024,  15'd3327,
        15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
        15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,
        15'd9493,  15'd10442, 15'd11487, 15'd12635, 15'd13899,
        15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385,
        15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

    // Step index adjustment by code magnitude
    function automatic logic signed [4:0] step_move(input logic [2:0] q);
        logic signed [4:0] mv;
        case (q)
            3'd4:    mv = 5'sd2;
            3'd5:    mv = 5'sd4;
            3'd6:    mv = 5'sd6;
            3'd7:    mv = 5'sd8;
            default: mv = -5'sd1;
        endcase
        return mv;
    endfunction

endpackage

### rtl/imaenc_front.sv
// Front end: configuration registers, block position counter, sample classification.
module imaenc_front import imaenc_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       i_full,
    output logic                       o_push,
    output t_job                       o_job
);

    logic [CHAN_W-1:0]   r_chan;
    logic [GROUPS_W-1:0] r_groups;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;

    logic                stereo;
    logic [GROUPS_W-1:0] groups_eff;
    logic [CNT_W-1:0]    last_pos;
    logic [CNT_W-1:0]    pos;
    logic [CNT_W-1:0]    code_pos;
    logic                at_end;

    assign stereo     = r_chan[1];
    assign groups_eff = (r_groups == '0) ? GROUPS_W'(1) : r_groups;

    // Last position: mono 8g, stereo 16g + 1
    assign last_pos = stereo ? ({groups_eff, 4'b0000} + CNT_W'(1))
                             : {1'b0, groups_eff, 3'b000};

    assign pos      = (r_count > last_pos) ? '0 : r_count;
    assign at_end   = (pos == last_pos);
    assign n_count  = at_end ? '0 : pos + CNT_W'(1);
    assign code_pos = pos - (stereo ? CNT_W'(2) : CNT_W'(1));

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

    // Classify the sample
    always_comb begin
        o_job.sample    = i_sample_value;
        o_job.at_end    = at_end;
        o_job.is_header = stereo ? (pos < CNT_W'(2)) : (pos < CNT_W'(1));
        if (o_job.is_header) begin
            o_job.ch = pos[0] & stereo;
            o_job.k  = '0;
        end else if (stereo) begin
            o_job.ch = code_pos[0];
            o_job.k  = code_pos[3:1];
        end else begin
            o_job.ch = 1'b0;
            o_job.k  = code_pos[2:0];
        end
    end

    // Registers and counter; a register write restarts the block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan   <= CHAN_RESET;
            r_groups <= GROUPS_RESET;
            r_count  <= '0;
        end else if (i_cfg_we) begin
            r_count <= '0;
            case (i_cfg_index)
                REG_CHANNEL_COUNT:    r_chan   <= i_cfg_data[CHAN_W-1:0];
                REG_GROUPS_PER_BLOCK: r_groups <= i_cfg_data[GROUPS_W-1:0];
                default: ;
            endcase
        end else if (o_push) begin
            r_count <= n_count;
        end
    end

endmodule

### rtl/imaenc_fifo.sv
// Short item queue between front end and back end.
module imaenc_fifo import imaenc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_valid,
    output logic o_full
);

    t_job               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr;
    logic [FIFO_AW-1:0] r_rptr;
    logic [FIFO_CW-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == FIFO_CW'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wptr + FIFO_AW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rptr + FIFO_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + FIFO_CW'(1);
                2'b01:   r_cnt <= r_cnt - FIFO_CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### rtl/imaenc_back.sv
// Back end: quantizer, predictor update, nibble packing and byte output register.
module imaenc_back import imaenc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_job               i_job,
    input  logic               i_job_valid,
    output logic               o_job_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [BYTE_W-1:0]  o_out_byte,
    output logic               o_run_last,
    output logic               o_block_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_MUL,
        S_UPD,
        S_EMIT
    } t_state;

    t_state                     r_state;
    t_job                       r_job;
    logic signed [SAMPLE_W-1:0] r_pred [2];
    logic [POS_W-1:0]           r_pos  [2];
    logic [3:0]                 r_pend [2];
    logic [BYTE_W-1:0]          r_hold [3];
    logic [NUM_W-1:0]           r_num;
    logic [STEP_W-1:0]          r_step;
    logic                       r_neg;
    logic [2:0]                 r_q;
    logic [1:0]                 r_dbit;
    logic [PROD_W-1:0]          r_prod;
    logic [BYTE_W-1:0]          r_ebuf [4];
    logic [1:0]                 r_eidx;
    logic [1:0]                 r_elast;
    logic                       r_eblk;
    logic                       r_out_valid;
    logic [BYTE_W-1:0]          r_out_byte;
    logic                       r_out_run_last;
    logic                       r_out_block_last;

    logic signed [SAMPLE_W-1:0] cur_pred;
    logic [POS_W-1:0]           cur_pos;
    logic [POS_W-1:0]           pos_c;
    logic signed [SAMPLE_W:0]   delta;
    logic [SAMPLE_W:0]          mag;
    logic [NUM_W-1:0]           shifted;
    logic                       num_ge;
    logic [SAMPLE_W-1:0]        move;
    logic signed [SAMPLE_W+1:0] pred_sum;
    logic signed [SAMPLE_W-1:0] pred_new;
    logic signed [8:0]          pos_sum;
    logic [POS_W-1:0]           pos_new;
    logic [3:0]                 code;
    logic [BYTE_W-1:0]          packed_byte;
    logic                       out_free;
    logic                       emit_now;

    // Current channel state
    assign cur_pred = r_pred[r_job.ch];
    assign cur_pos  = r_pos[r_job.ch];
    assign pos_c    = (cur_pos > STEP_TOP) ? STEP_TOP : cur_pos;

    // Difference and magnitude
    assign delta = $signed({r_job.sample[SAMPLE_W-1], r_job.sample})
                 - $signed({cur_pred[SAMPLE_W-1], cur_pred});
    assign mag   = delta[SAMPLE_W] ? (~delta + 1'b1) : delta;

    // One quotient bit per cycle; the first step checks for saturation at 7
    assign shifted = NUM_W'(r_step) << r_dbit;
    assign num_ge  = (r_num >= shifted);

    // Predictor update with 16-bit saturation
    assign move     = r_prod[PROD_W-1:3];
    assign pred_sum = r_neg ? ($signed({{2{cur_pred[SAMPLE_W-1]}}, cur_pred})
                               - $signed({2'b00, move}))
                            : ($signed({{2{cur_pred[SAMPLE_W-1]}}, cur_pred})
                               + $signed({2'b00, move}));
    always_comb begin
        if (pred_sum > $signed({{2{PRED_MAX[SAMPLE_W-1]}}, PRED_MAX})) begin
            pred_new = PRED_MAX;
        end else if (pred_sum < $signed({{2{PRED_MIN[SAMPLE_W-1]}}, PRED_MIN})) begin
            pred_new = PRED_MIN;
        end else begin
            pred_new = pred_sum[SAMPLE_W-1:0];
        end
    end

    // Step index update, clamped to 0..88
    assign pos_sum = $signed({2'b00, pos_c}) + 9'(step_move(r_q));
    always_comb begin
        if (pos_sum < 9'sd0) begin
            pos_new = '0;
        end else if (pos_sum > $signed({2'b00, STEP_TOP})) begin
            pos_new = STEP_TOP;
        end else begin
            pos_new = pos_sum[POS_W-1:0];
        end
    end

    assign code        = {r_neg, r_q};
    assign packed_byte = {code, r_pend[r_job.ch]};

    assign out_free  = !r_out_valid || !i_out_stall;
    assign emit_now  = (r_state == S_EMIT) && out_free;
    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_run_last   = r_out_run_last;
    assign o_block_last = r_out_block_last;

    // Sequencer, channel state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pred[0]   <= '0;
            r_pred[1]   <= '0;
            r_pos[0]    <= '0;
            r_pos[1]    <= '0;
            r_pend[0]   <= '0;
            r_pend[1]   <= '0;
            r_hold[0]   <= '0;
            r_hold[1]   <= '0;
            r_hold[2]   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Output valid: set on a new byte, cleared once the byte is taken
            if (emit_now) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job;
                        if (i_job.is_header) begin
                            // Header: predictor low, high, step index, zero
                            r_pred[i_job.ch] <= i_job.sample;
                            r_ebuf[0] <= i_job.sample[7:0];
                            r_ebuf[1] <= i_job.sample[15:8];
                            r_ebuf[2] <= {1'b0, r_pos[i_job.ch]};
                            r_ebuf[3] <= '0;
                            r_eidx    <= 2'd0;
                            r_elast   <= 2'd3;
                            r_eblk    <= i_job.at_end;
                            r_state   <= S_EMIT;
                        end else begin
                            r_state <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    r_num   <= {mag[SAMPLE_W-1:0], 2'b00};
                    r_step  <= STEP_SIZES[pos_c];
                    r_neg   <= delta[SAMPLE_W];
                    r_q     <= '0;
                    r_dbit  <= 2'd3;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_dbit == 2'd3) begin
                        if (num_ge) begin
                            r_q     <= 3'd7;
                            r_state <= S_MUL;
                        end else begin
                            r_dbit <= 2'd2;
                        end
                    end else begin
                        if (num_ge) begin
                            r_num <= r_num - shifted;
                            r_q   <= r_q | (3'b001 << r_dbit);
                        end
                        if (r_dbit == 2'd0) begin
                            r_state <= S_MUL;
                        end else begin
                            r_dbit <= r_dbit - 2'd1;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(r_step) * PROD_W'({r_q, 1'b1});
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_pred[r_job.ch] <= pred_new;
                    r_pos[r_job.ch]  <= pos_new;
                    if (!r_job.k[0]) begin
                        // Low nibble waits for its partner
                        r_pend[r_job.ch] <= code;
                        r_state <= S_IDLE;
                    end else if (!r_job.ch) begin
                        r_ebuf[0] <= packed_byte;
                        r_eidx    <= 2'd0;
                        r_elast   <= 2'd0;
                        r_eblk    <= r_job.at_end;
                        r_state   <= S_EMIT;
                    end else if (r_job.k != 3'd7) begin
                        // Right channel bytes wait for the end of the group
                        r_hold[r_job.k[2:1]] <= packed_byte;
                        r_state <= S_IDLE;
                    end else begin
                        r_ebuf[0] <= r_hold[0];
                        r_ebuf[1] <= r_hold[1];
                        r_ebuf[2] <= r_hold[2];
                        r_ebuf[3] <= packed_byte;
                        r_eidx    <= 2'd0;
                        r_elast   <= 2'd3;
                        r_eblk    <= r_job.at_end;
                        r_state   <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_byte       <= r_ebuf[r_eidx];
                        r_out_run_last   <= (r_eidx == r_elast);
                        r_out_block_last <= (r_eidx == r_elast) && r_eblk;
                        if (r_eidx == r_elast) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_eidx <= r_eidx + 2'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos[0] <= STEP_TOP) && (r_pos[1] <= STEP_TOP))
        else $error("step index out of range");

    a_block_last_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_block_last) |-> o_run_last)
        else $error("block end not on the last byte of a sample");

    a_div_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> ((r_q == 3'd7) || (r_num < NUM_W'(r_step))))
        else $error("quotient remainder not below step");

    a_emit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_eidx <= r_elast))
        else $error("byte index past last byte");
`endif

endmodule

### rtl/ima_adpcm_block_encoder.sv
// IMA-ADPCM block encoder top level: front end, item queue, back end.
// A header item passes through the queue, the back end's byte buffer and the output register;
// its bytes then follow one a cycle while the output is not stalled. A coded item that completes
// a byte is first sequenced by the back end (three-bit quotient with early exit at 7, multiply,
// update) before byte emission; the back end takes a new item only once it is idle again.
// Reset (synchronous, active low) sets mono, 80 groups, and clears predictors, step indexes, queue.
module ima_adpcm_block_encoder import imaenc_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [BYTE_W-1:0]          o_out_byte,
    output logic                       o_run_last,
    output logic                       o_block_last,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    t_job push_job;
    t_job pop_job;
    logic push;
    logic pop;
    logic q_valid;
    logic q_full;

    // Accept and classify samples
    imaenc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_value (i_sample_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_full         (q_full),
        .o_push         (push),
        .o_job          (push_job)
    );

    // Decouple the two sides
    imaenc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    // Encode and emit bytes
    imaenc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (pop_job),
        .i_job_valid  (q_valid),
        .o_job_pop    (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_block_last (o_block_last)
    );

endmodule

### test/imaenc_checker.sv
// Scoreboard for the IMA-ADPCM block encoder: predicts block bytes and compares them.
module imaenc_checker import imaenc_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [BYTE_W-1:0]          i_out_byte,
    input  logic                       i_run_last,
    input  logic                       i_block_last,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              run_last;
        logic              block_last;
    } t_enc_byte;

    // Step index change by code magnitude
    localparam int STEP_ADJUST [8] = '{-1, -1, -1, -1, 2, 4, 6, 8};

    logic [CHAN_W-1:0]          chan_cfg;
    logic [GROUPS_W-1:0]        groups_cfg;
    logic signed [SAMPLE_W-1:0] pred_val [2];
    logic [POS_W-1:0]           step_idx [2];
    logic [3:0]                 low_code [2];
    logic [BYTE_W-1:0]          right_hold [3];
    int                         block_pos;
    int                         mismatch_cnt;
    t_enc_byte                  encoded_bytes_q [$];

    function automatic void push_byte(input logic [BYTE_W-1:0] value, input logic run_last,
                                      input logic block_last);
        t_enc_byte b;
        b.value      = value;
        b.run_last   = run_last;
        b.block_last = block_last;
        encoded_bytes_q.push_back(b);
    endfunction

    // Quantize one sample against the channel predictor, then adapt predictor and step
    function automatic logic [3:0] adpcm_code(input int ch, input logic signed [SAMPLE_W-1:0] s);
        int step;
        int delta;
        int mag;
        int q;
        int move;
        int p;
        int np;
        step  = int'(STEP_SIZES[step_idx[ch]]);
        delta = int'(s) - int'(pred_val[ch]);
        mag   = (delta < 0) ? -delta : delta;
        q     = (mag * 4) / step;
        if (q > 7) q = 7;
        move = (step * (2 * q + 1)) / 8;
        p    = int'(pred_val[ch]) + ((delta < 0) ? -move : move);
        if (p > 32767) p = 32767;
        if (p < -32768) p = -32768;
        pred_val[ch] = 16'(p);
        np = int'(step_idx[ch]) + STEP_ADJUST[q];
        if (np < 0) np = 0;
        if (np > int'(STEP_TOP)) np = int'(STEP_TOP);
        step_idx[ch] = 7'(np);
        return {delta < 0, 3'(q)};
    endfunction

    // Work out the bytes that one accepted sample causes
    function automatic void encode_sample(input logic signed [SAMPLE_W-1:0] s);
        int               chans;
        int               groups;
        int               last_pos;
        int               pos;
        int               q;
        int               ch;
        int               k;
        logic             at_end;
        logic [3:0]       code;
        logic [BYTE_W-1:0] b;
        chans    = chan_cfg[1] ? 2 : 1;
        groups   = (groups_cfg == '0) ? 1 : int'(groups_cfg);
        last_pos = chans * (1 + 8 * groups) - 1;
        pos      = (block_pos > last_pos) ? 0 : block_pos;
        at_end   = (pos == last_pos);
        block_pos = at_end ? 0 : pos + 1;

        // Header sample: loads the predictor, emits four bytes
        if (pos < chans) begin
            pred_val[pos] = s;
            push_byte(s[7:0], 1'b0, 1'b0);
            push_byte(s[15:8], 1'b0, 1'b0);
            push_byte({1'b0, step_idx[pos]}, 1'b0, 1'b0);
            push_byte('0, 1'b1, at_end);
            return;
        end

        q  = pos - chans;
        ch = chan_cfg[1] ? (q & 1) : 0;
        k  = chan_cfg[1] ? ((q >> 1) & 7) : (q & 7);
        code = adpcm_code(ch, s);
        if ((k & 1) == 0) begin
            low_code[ch] = code;
            return;
        end
        b = {code, low_code[ch]};
        if (ch == 0) begin
            push_byte(b, 1'b1, at_end);
            return;
        end
        // Right channel bytes wait until the left channel's bytes of the group are out
        if (k < 7) begin
            right_hold[(k >> 1) & 3] = b;
            return;
        end
        for (int n = 0; n < 3; n++) push_byte(right_hold[n], 1'b0, 1'b0);
        push_byte(b, 1'b1, at_end);
    endfunction

    function automatic void check_byte();
        t_enc_byte want;
        if (encoded_bytes_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("%0t: unexpected byte %h run_last %b block_last %b", $time,
                         i_out_byte, i_run_last, i_block_last);
            return;
        end
        want = encoded_bytes_q.pop_front();
        if (want.value !== i_out_byte || want.run_last !== i_run_last ||
            want.block_last !== i_block_last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("%0t: byte mismatch: expected %h/%b/%b, got %h/%b/%b", $time,
                         want.value, want.run_last, want.block_last,
                         i_out_byte, i_run_last, i_block_last);
        end
    endfunction

    // Track register writes, accepted samples and accepted bytes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            chan_cfg   = CHAN_RESET;
            groups_cfg = GROUPS_RESET;
            block_pos  = 0;
            for (int n = 0; n < 2; n++) begin
                pred_val[n] = '0;
                step_idx[n] = '0;
                low_code[n] = '0;
            end
            for (int n = 0; n < 3; n++) right_hold[n] = '0;
            encoded_bytes_q.delete();
        end else begin
            // Any register write restarts the block
            if (i_cfg_we) begin
                if (i_cfg_index == REG_CHANNEL_COUNT) begin
                    chan_cfg  = i_cfg_data[CHAN_W-1:0];
                    block_pos = 0;
                end else if (i_cfg_index == REG_GROUPS_PER_BLOCK) begin
                    groups_cfg = i_cfg_data[GROUPS_W-1:0];
                    block_pos  = 0;
                end
            end
            if (i_in_valid && !i_in_stall) encode_sample(i_sample_value);
            if (i_out_valid && !i_out_stall) check_byte();
        end
        o_fail_count <= mismatch_cnt;
        o_pending    <= encoded_bytes_q.size();
    end

endmodule

### test/testbench.sv
// Top of the encoder testbench: clock, reset, sample and register stimulus, verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import imaenc_pkg::*;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic signed [SAMPLE_W-1:0] i_sample_value;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic [BYTE_W-1:0]          o_out_byte;
    logic                       o_run_last;
    logic                       o_block_last;
    logic                       i_cfg_we;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [CFG_DATA_W-1:0]      i_cfg_data;

    int fail_count;
    int bytes_pending;
    int bytes_taken;
    int samples_sent;
    int last_sample;
    bit feeding;
    bit pressure_done;

    // Extremes, predictor saturation both ways, step index clamps, bit patterns
    localparam logic signed [SAMPLE_W-1:0] EDGE_SAMPLES [21] = '{
        16'sh0000, 16'sh0000, 16'sh0001, 16'shFFFF,
        16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
        16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
        16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
        16'sh5555, 16'shAAAA, 16'sh0000
    };

    ima_adpcm_block_encoder u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_value (i_sample_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_run_last     (o_run_last),
        .o_block_last   (o_block_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    imaenc_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_sample_value (i_sample_value),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out_byte     (o_out_byte),
        .i_run_last     (o_run_last),
        .i_block_last   (o_block_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (bytes_pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk)
        if (o_out_valid && !i_out_stall) bytes_taken++;

    // Idle length: mostly none, some short, a few long
    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Output side: random stalls, quiet stretches, one long hold-off while samples flow
    initial begin : byte_sink
        int hold_left;
        bit stall_next;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!pressure_done && feeding && bytes_taken >= 60) begin
                pressure_done = 1'b1;
                hold_left     = 300;
            end else if (hold_left == 0) begin
                hold_left = pick_gap(((bytes_taken / 64) % 4) == 1);
            end
            stall_next = (hold_left > 0);
            if (hold_left > 0) hold_left--;
            i_out_stall <= stall_next;
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        int gap;
        gap = pick_gap(((samples_sent / 40) % 4) == 1);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample_value <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        samples_sent++;
    endtask

    // Stop offering samples and let the encoder drain, including samples with no byte
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (bytes_pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mix of a smooth signal, full-range noise and extremes
    function automatic logic signed [SAMPLE_W-1:0] next_sample();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            v = last_sample + int'($urandom_range(0, 4000)) - 2000;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
        end else if (r < 85) begin
            v = int'(16'($urandom));
            v = (v > 32767) ? v - 65536 : v;
        end else begin
            case ($urandom_range(0, 3))
                0:       v = 32767;
                1:       v = -32768;
                2:       v = 0;
                default: v = -1;
            endcase
        end
        last_sample = v;
        return 16'(v);
    endfunction

    task automatic send_random(input int count);
        feeding = 1'b1;
        repeat (count) send_sample(next_sample());
        feeding = 1'b0;
    endtask

    initial begin : stimulus
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_sample_value = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = REG_CHANNEL_COUNT;
        i_cfg_data     = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: mono, 80 groups
        foreach (EDGE_SAMPLES[n]) send_sample(EDGE_SAMPLES[n]);

        // Stereo, one group per block
        write_reg(REG_CHANNEL_COUNT, 8'd2);
        write_reg(REG_GROUPS_PER_BLOCK, 8'd1);
        send_random(36);

        // Odd count still means stereo; zero groups acts as one
        write_reg(REG_CHANNEL_COUNT, 8'd3);
        write_reg(REG_GROUPS_PER_BLOCK, 8'd0);
        send_random(30);

        // Zero count means mono; two groups per block
        write_reg(REG_CHANNEL_COUNT, 8'd0);
        write_reg(REG_GROUPS_PER_BLOCK, 8'd2);
        send_random(34);

        // Largest block, mono
        write_reg(REG_CHANNEL_COUNT, 8'd1);
        write_reg(REG_GROUPS_PER_BLOCK, 8'd255);
        send_random(15);

        // Register write in mid block restarts it
        write_reg(REG_CHANNEL_COUNT, 8'd2);
        write_reg(REG_GROUPS_PER_BLOCK, 8'd3);
        send_random(20);

        drain();
        if (fail_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule
